// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helper macros included by the checker file altbl_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ALT_ASSERT(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error(msg);

// Property checked on the edge after reset has been seen low.
`define ALT_ASSERT_RST(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) (!rstn) |=> (expr)) \
        else $error(msg);

`endif

// File: hw/rtl/altbl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// altbl_pkg
// Shared types and codes for the array list table.
// ----------------------------------------------------------------------------
package altbl_pkg;

    // Operation codes carried in the input transaction
    typedef enum logic [2:0] {
        OP_CLEAR  = 3'd0,
        OP_APPEND = 3'd1,
        OP_INSERT = 3'd2,
        OP_REMOVE = 3'd3,
        OP_SEARCH = 3'd4,
        OP_RMVAL  = 3'd5
    } op_t;

    // Sequencer states, one-hot
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SCAN = 5'b00010,
        ST_SHUP = 5'b00100,
        ST_SHDN = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    // Result of one operation
    typedef struct packed {
        logic       is_full;
        logic       is_empty;
        logic [4:0] count;
        logic [3:0] found_index;
        logic       ok;
    } result_t;

endpackage

// File: hw/rtl/array_list_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_list_table_core
// Ordered list of signed 32-bit values with clear, append, insert, remove,
// search and remove-by-value operations.
// ----------------------------------------------------------------------------
// Usage:
//   One operation enters on the s_ channel and gives exactly one result on
//   the m_ channel. One operation is worked on at a time; s_tready is high
//   only while the sequencer is idle.
//   Clear, append, failed checks and unused codes go straight to the final
//   step; insert, remove, search and remove-value walk the entry memory
//   one entry per cycle through its single read port. The next operation
//   is accepted once the sequencer has returned to idle after handing its
//   result over to the output register.
//   A result waits in the output register while m_tready is low; the next
//   operation is still accepted and worked on, and holds in its final step
//   until the output register is free.
//   Reset empties the list; the entry memory is not cleared and needs no
//   clearing pass.
// ----------------------------------------------------------------------------
module array_list_table_core #(
    parameter int CAPACITY = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // operation in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [2:0] operation, [34:3] value, [39:35] position
    // result out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [0] ok, [4:1] found_index, [9:5] count,
                                   // [10] is_empty, [11] is_full, [15:12] zero
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    logic               res_valid;
    logic               res_ready;
    altbl_pkg::result_t res;

    logic               mem_we;
    logic [IW-1:0]      mem_waddr;
    logic [31:0]        mem_wdata;
    logic               mem_re;
    logic [IW-1:0]      mem_raddr;
    logic [31:0]        mem_rdata;

    logic               m_valid_reg;
    altbl_pkg::result_t m_res_reg;

    altbl_seq #(
        .CAPACITY (CAPACITY),
        .CW       (CW),
        .IW       (IW)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_op       (s_tdata[2:0]),
        .in_value    (s_tdata[34:3]),
        .in_position (s_tdata[39:35]),
        .res_ready   (res_ready),
        .res_valid   (res_valid),
        .res         (res),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

    altbl_ram #(
        .DEPTH (CAPACITY),
        .AW    (IW),
        .W     (32)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // output register: free when empty or being drained this cycle
    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, m_res_reg};

endmodule

// File: hw/rtl/altbl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// altbl_ram
// Simple dual-port entry memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module altbl_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int W     = 32
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [W-1:0]  wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [W-1:0]  rd_data
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/altbl_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// altbl_seq
// Operation sequencer: holds the entry count and walks the entry memory
// for search and shift operations, one entry per cycle.
// ----------------------------------------------------------------------------
module altbl_seq #(
    parameter int CAPACITY = 16,
    parameter int CW       = 5,
    parameter int IW       = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    // operation in
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          in_op,
    input  logic [31:0]         in_value,
    input  logic [4:0]          in_position,
    // result out
    input  logic                res_ready,
    output logic                res_valid,
    output altbl_pkg::result_t  res,
    // entry memory
    output logic                mem_we,
    output logic [IW-1:0]       mem_waddr,
    output logic [31:0]         mem_wdata,
    output logic                mem_re,
    output logic [IW-1:0]       mem_raddr,
    input  logic [31:0]         mem_rdata
);

    localparam int CMPW = (CW > 5) ? CW : 5;

    altbl_pkg::state_t state_reg, state_next;
    altbl_pkg::op_t    op_reg, op_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     pipe_idx_reg, pipe_idx_next;
    logic              pipe_vld_reg, pipe_vld_next;
    logic [CW-1:0]     pos_reg, pos_next;
    logic [31:0]       value_reg, value_next;
    logic              ok_reg, ok_next;
    logic [3:0]        fidx_reg, fidx_next;

    logic              full;
    logic              hit;
    logic [CMPW-1:0]   pos_w;
    logic [CMPW-1:0]   cnt_w;

    assign full  = (count_reg == CW'(CAPACITY));
    assign hit   = pipe_vld_reg && (mem_rdata == value_reg);
    assign pos_w = CMPW'(in_position);
    assign cnt_w = CMPW'(count_reg);

    assign in_ready = (state_reg == altbl_pkg::ST_IDLE);

    // next-state and memory access control
    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        pipe_idx_next = pipe_idx_reg;
        pipe_vld_next = pipe_vld_reg;
        pos_next      = pos_reg;
        value_next    = value_reg;
        ok_next       = ok_reg;
        fidx_next     = fidx_reg;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = value_reg;
        mem_re        = 1'b0;
        mem_raddr     = '0;
        res_valid     = 1'b0;

        case (state_reg)
            altbl_pkg::ST_IDLE: begin
                if (in_valid) begin
                    value_next    = in_value;
                    op_next       = altbl_pkg::op_t'(in_op);
                    ok_next       = 1'b0;
                    fidx_next     = '0;
                    pipe_vld_next = 1'b0;
                    state_next    = altbl_pkg::ST_DONE;
                    case (altbl_pkg::op_t'(in_op))
                        altbl_pkg::OP_CLEAR: begin
                            count_next = '0;
                            ok_next    = 1'b1;
                        end
                        altbl_pkg::OP_APPEND: begin
                            if (!full) begin
                                mem_we     = 1'b1;
                                mem_waddr  = IW'(count_reg);
                                mem_wdata  = in_value;
                                count_next = count_reg + CW'(1);
                                ok_next    = 1'b1;
                            end
                        end
                        altbl_pkg::OP_INSERT: begin
                            if (!full && (pos_w <= cnt_w)) begin
                                pos_next   = CW'(in_position);
                                idx_next   = count_reg;
                                state_next = altbl_pkg::ST_SHUP;
                            end
                        end
                        altbl_pkg::OP_REMOVE: begin
                            if (pos_w < cnt_w) begin
                                pos_next   = CW'(in_position);
                                idx_next   = CW'(in_position) + CW'(1);
                                state_next = altbl_pkg::ST_SHDN;
                            end
                        end
                        altbl_pkg::OP_SEARCH, altbl_pkg::OP_RMVAL: begin
                            idx_next   = '0;
                            state_next = altbl_pkg::ST_SCAN;
                        end
                        default: begin
                            // unused code: no change, failure reported
                        end
                    endcase
                end
            end

            // sequential scan for the first match
            altbl_pkg::ST_SCAN: begin
                if (hit) begin
                    pipe_vld_next = 1'b0;
                    if (op_reg == altbl_pkg::OP_SEARCH) begin
                        ok_next    = 1'b1;
                        fidx_next  = 4'(pipe_idx_reg);
                        state_next = altbl_pkg::ST_DONE;
                    end else begin
                        pos_next   = pipe_idx_reg;
                        idx_next   = pipe_idx_reg + CW'(1);
                        state_next = altbl_pkg::ST_SHDN;
                    end
                end else if (idx_reg < count_reg) begin
                    mem_re        = 1'b1;
                    mem_raddr     = IW'(idx_reg);
                    pipe_vld_next = 1'b1;
                    pipe_idx_next = idx_reg;
                    idx_next      = idx_reg + CW'(1);
                end else if (!pipe_vld_reg) begin
                    state_next = altbl_pkg::ST_DONE;
                end else begin
                    pipe_vld_next = 1'b0;
                end
            end

            // move later entries down by one: read i+1, write i
            altbl_pkg::ST_SHDN: begin
                if (pipe_vld_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = IW'(pipe_idx_reg - CW'(1));
                    mem_wdata = mem_rdata;
                end
                if (idx_reg < count_reg) begin
                    mem_re        = 1'b1;
                    mem_raddr     = IW'(idx_reg);
                    pipe_vld_next = 1'b1;
                    pipe_idx_next = idx_reg;
                    idx_next      = idx_reg + CW'(1);
                end else begin
                    pipe_vld_next = 1'b0;
                    if (!pipe_vld_reg) begin
                        count_next = count_reg - CW'(1);
                        ok_next    = 1'b1;
                        state_next = altbl_pkg::ST_DONE;
                    end
                end
            end

            // move entries up by one from the top: read i-1, write i
            altbl_pkg::ST_SHUP: begin
                if (pipe_vld_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = IW'(pipe_idx_reg);
                    mem_wdata = mem_rdata;
                end
                if (idx_reg > pos_reg) begin
                    mem_re        = 1'b1;
                    mem_raddr     = IW'(idx_reg - CW'(1));
                    pipe_vld_next = 1'b1;
                    pipe_idx_next = idx_reg;
                    idx_next      = idx_reg - CW'(1);
                end else begin
                    pipe_vld_next = 1'b0;
                    if (!pipe_vld_reg) begin
                        mem_we     = 1'b1;
                        mem_waddr  = IW'(pos_reg);
                        mem_wdata  = value_reg;
                        count_next = count_reg + CW'(1);
                        ok_next    = 1'b1;
                        state_next = altbl_pkg::ST_DONE;
                    end
                end
            end

            // hand the result over once the output stage is free
            altbl_pkg::ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = altbl_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = altbl_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= altbl_pkg::ST_IDLE;
            count_reg    <= '0;
            pipe_vld_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            pipe_vld_reg <= pipe_vld_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        idx_reg      <= idx_next;
        pipe_idx_reg <= pipe_idx_next;
        pos_reg      <= pos_next;
        value_reg    <= value_next;
        ok_reg       <= ok_next;
        fidx_reg     <= fidx_next;
    end

    // result fields
    always_comb begin
        res.ok          = ok_reg;
        res.found_index = fidx_reg;
        res.count       = 5'(count_reg);
        res.is_empty    = (count_reg == '0);
        res.is_full     = full;
    end

endmodule

// File: hw/rtl/altbl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// altbl_checker
// Port-level checks on the result channel of the array list table.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module altbl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // no result is left over from before reset
    `ALT_ASSERT_RST(a_rst_idle, aclk, aresetn, !m_tvalid, "result valid after reset")

    // a stalled result holds
    `ALT_ASSERT(a_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "stalled result changed")

    // empty flag agrees with the count
    `ALT_ASSERT(a_empty, aclk, aresetn, (m_tvalid && m_tdata[10]) |-> (m_tdata[9:5] == 5'd0), "empty with nonzero count")

    // a list cannot be empty and full together
    `ALT_ASSERT(a_excl, aclk, aresetn, m_tvalid |-> !(m_tdata[10] && m_tdata[11]), "empty and full together")

    // a nonzero match index comes only with success
    `ALT_ASSERT(a_fidx, aclk, aresetn, (m_tvalid && (m_tdata[4:1] != 4'd0)) |-> m_tdata[0], "match index without success")

endmodule

bind array_list_table_core altbl_checker u_altbl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
